// ===== rtl/vtv_pkg.sv =====
// Shared types and constants for the vertex transform and viewport block.
package vtv_pkg;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_VERTEX = 1'b1;

  localparam logic MAT_PROJ  = 1'b0;
  localparam logic MAT_MODEL = 1'b1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_START    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_FALLOFF  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_BRIGHTNESS = 3'd4;

  localparam logic [12:0] RST_FRAME_WIDTH    = 13'd64;
  localparam logic [12:0] RST_FRAME_HEIGHT   = 13'd64;
  localparam logic [19:0] RST_LIGHT_START    = 20'd39592;
  localparam logic [19:0] RST_LIGHT_FALLOFF  = 20'd12000;
  localparam logic [16:0] RST_MIN_BRIGHTNESS = 17'd2570;

  localparam logic [16:0] BRI_ONE = 17'd65536;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  typedef struct packed {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic signed [31:0] vw;
    logic [15:0]        color;
  } vtx_t;

  typedef logic [15:0][31:0] mat_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== rtl/vtv_front.sv =====
// Request intake: classifies requests, holds both matrices, queues vertices.
module vtv_front import vtv_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               opcode,
  input  logic               matrix_select,
  input  logic [3:0]         element_index,
  input  logic signed [31:0] element_value,
  input  logic signed [31:0] vx,
  input  logic signed [31:0] vy,
  input  logic signed [31:0] vz,
  input  logic signed [31:0] vw,
  input  logic [15:0]        vertex_color,
  input  q_status_t          q_stat,
  input  logic               back_busy,
  output logic               push,
  output vtx_t               push_data,
  output mat_t               proj,
  output mat_t               model
);

  logic wr_ok;
  logic wr_fire;

  assign wr_ok    = q_stat.empty && !back_busy;
  assign in_ready = (opcode == OP_VERTEX) ? !q_stat.full : wr_ok;
  assign push     = in_valid && in_ready && (opcode == OP_VERTEX);
  assign wr_fire  = in_valid && in_ready && (opcode == OP_WRITE);

  assign push_data = '{vx: vx, vy: vy, vz: vz, vw: vw, color: vertex_color};

  always_ff @(posedge clk) begin
    if (rst) begin
      proj  <= '0;
      model <= '0;
    end else if (wr_fire) begin
      if (matrix_select == MAT_MODEL) begin
        model[element_index] <= element_value;
      end else begin
        proj[element_index] <= element_value;
      end
    end
  end

endmodule

// ===== rtl/vtv_queue.sv =====
// Short vertex queue between intake and the transform pipeline.
module vtv_queue import vtv_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  vtx_t      push_data,
  input  logic      pop,
  output vtx_t      pop_data,
  output q_status_t q_stat
);

  vtx_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign q_stat.full  = (count == (QPTR_W+1)'(QDEPTH));
  assign q_stat.empty = (count == '0);
  assign pop_data     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/vtv_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
module vtv_div #(
  parameter int NUM_W = 48,
  parameter int DEN_W = 32,
  parameter int Q_W   = 32
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [Q_W-1:0]   quo,
  output logic             ovf
);

  logic [DEN_W-1:0] rem  [Q_W+1];
  logic [Q_W-1:0]   low  [Q_W+1];
  logic [Q_W-1:0]   q    [Q_W+1];
  logic [DEN_W-1:0] d    [Q_W+1];
  logic             ov   [Q_W+1];

  always_ff @(posedge clk) begin
    if (en) begin
      ov[0]  <= (num >> Q_W) >= NUM_W'(den);
      rem[0] <= DEN_W'(num >> Q_W);
      low[0] <= num[Q_W-1:0];
      q[0]   <= '0;
      d[0]   <= den;
    end
  end

  for (genvar i = 1; i <= Q_W; i++) begin : g_stage
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           ge;
    assign trial = {rem[i-1], low[i-1][Q_W-1]};
    assign diff  = trial - {1'b0, d[i-1]};
    assign ge    = trial >= {1'b0, d[i-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem[i] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        low[i] <= low[i-1] << 1;
        q[i]   <= {q[i-1][Q_W-2:0], ge};
        d[i]   <= d[i-1];
        ov[i]  <= ov[i-1];
      end
    end
  end

  assign quo = q[Q_W];
  assign ovf = ov[Q_W];

endmodule

// ===== rtl/vtv_back.sv =====
// Transform pipeline: matrix products, divides, viewport map and brightness.
module vtv_back import vtv_pkg::*; #(
  parameter int FRAC = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  q_status_t          q_stat,
  output logic               pop,
  input  vtx_t               pop_data,
  input  mat_t               proj,
  input  mat_t               model,
  input  logic [12:0]        frame_width,
  input  logic [12:0]        frame_height,
  input  logic [19:0]        light_start,
  input  logic [19:0]        light_falloff,
  input  logic [16:0]        min_brightness,
  output logic               busy,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] pixel_x,
  output logic signed [15:0] pixel_y,
  output logic signed [31:0] depth_ndc,
  output logic               xy_in_view,
  output logic               z_in_view,
  output logic               w_zero,
  output logic [47:0]        eye_distance_sq,
  output logic [16:0]        brightness,
  output logic [15:0]        color_out
);

  localparam int DIV_LAT = 33;
  localparam int NDC_N_W = 32 + FRAC;
  localparam int BRI_N_W = 36 + FRAC;
  localparam int BRI_D_W = 49;
  localparam logic signed [31:0] ONE  = 32'sd1 <<< FRAC;
  localparam logic signed [46:0] BIAS = (47'sd1 <<< (FRAC + 1)) - 47'sd1;

  typedef struct packed {
    logic        wz;
    logic        negx;
    logic        negy;
    logic        negz;
    logic        bzero;
    logic        bneg;
    logic [47:0] dsq;
    logic [15:0] color;
  } side_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    if (x > 66'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (x < -66'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return x[31:0];
    end
  endfunction

  function automatic logic signed [31:0] ndc_fix(input logic [31:0] m, input logic ov,
                                                  input logic neg);
    if (!neg) begin
      return (ov || m[31]) ? 32'sh7fffffff : $signed(m);
    end else begin
      return (ov || (m > 32'h80000000)) ? 32'sh80000000 : $signed(-m);
    end
  endfunction

  function automatic logic signed [15:0] pix_fix(input logic signed [46:0] p);
    logic signed [46:0] t;
    t = (p < 0) ? ((p + BIAS) >>> (FRAC + 1)) : (p >>> (FRAC + 1));
    if (t > 47'sd32767) begin
      return 16'sh7fff;
    end else if (t < -47'sd32768) begin
      return 16'sh8000;
    end else begin
      return t[15:0];
    end
  endfunction

  logic en;
  assign en  = !out_valid || out_ready;
  assign pop = !q_stat.empty && en;

  // stage 1: modelview products
  logic signed [31:0] vin [4];
  logic signed [63:0] p1 [4][4];
  logic               v1;
  logic [15:0]        col1;

  assign vin[0] = pop_data.vx;
  assign vin[1] = pop_data.vy;
  assign vin[2] = pop_data.vz;
  assign vin[3] = pop_data.vw;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          p1[r][c] <= $signed(model[4'(r + 4 * c)]) * vin[c];
        end
      end
      col1 <= pop_data.color;
    end
  end

  // stage 2: eye position
  logic signed [31:0] eye2 [4];
  logic signed [31:0] eye_c [4];
  logic               v2;
  logic [15:0]        col2;

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      eye_c[r] = sat32(66'(p1[r][0] >>> FRAC) + 66'(p1[r][1] >>> FRAC)
                       + 66'(p1[r][2] >>> FRAC) + 66'(p1[r][3] >>> FRAC));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      eye2 <= eye_c;
      col2 <= col1;
    end
  end

  // stage 3: projection products and squares
  logic signed [63:0] p3 [4][4];
  logic signed [63:0] sq3 [3];
  logic               v3;
  logic [15:0]        col3;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          p3[r][c] <= $signed(proj[4'(r + 4 * c)]) * eye2[c];
        end
      end
      for (int i = 0; i < 3; i++) begin
        sq3[i] <= eye2[i] * eye2[i];
      end
      col3 <= col2;
    end
  end

  // stage 4: clip position and distance
  logic signed [31:0] clip4 [4];
  logic signed [31:0] clip_c [4];
  logic [63:0]        sq_sum;
  logic [63:0]        dist_w;
  logic [47:0]        dist4;
  logic               v4;
  logic [15:0]        col4;

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      clip_c[r] = sat32(66'(p3[r][0] >>> FRAC) + 66'(p3[r][1] >>> FRAC)
                        + 66'(p3[r][2] >>> FRAC) + 66'(p3[r][3] >>> FRAC));
    end
  end

  assign sq_sum = 64'(unsigned'(sq3[0])) + 64'(unsigned'(sq3[1]))
                + 64'(unsigned'(sq3[2]));
  assign dist_w = sq_sum >> FRAC;

  always_ff @(posedge clk) begin
    if (en) begin
      clip4 <= clip_c;
      dist4 <= (dist_w > 64'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : dist_w[47:0];
      col4  <= col3;
    end
  end

  // divider inputs
  logic [31:0]        mag [4];
  logic [49:0]        bden;
  logic [BRI_N_W-1:0] bnum;
  side_t              side_in;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mag[i] = clip4[i][31] ? -clip4[i] : clip4[i];
    end
  end

  assign bden = (50'(light_falloff) << FRAC) + 50'(dist4) - (50'(light_start) << FRAC);
  assign bnum = BRI_N_W'(light_falloff) << (16 + FRAC);

  assign side_in = '{wz:    (clip4[3] == 32'sd0),
                     negx:  clip4[0][31] ^ clip4[3][31],
                     negy:  clip4[1][31] ^ clip4[3][31],
                     negz:  clip4[2][31] ^ clip4[3][31],
                     bzero: (bden == '0),
                     bneg:  bden[49],
                     dsq:   dist4,
                     color: col4};

  logic [31:0] qx, qy, qz, qb;
  logic        ox, oy, oz, ob;

  vtv_div #(.NUM_W(NDC_N_W), .DEN_W(32), .Q_W(32)) u_div_x (
    .clk(clk), .en(en), .num({mag[0], FRAC'(0)}), .den(mag[3]), .quo(qx), .ovf(ox)
  );
  vtv_div #(.NUM_W(NDC_N_W), .DEN_W(32), .Q_W(32)) u_div_y (
    .clk(clk), .en(en), .num({mag[1], FRAC'(0)}), .den(mag[3]), .quo(qy), .ovf(oy)
  );
  vtv_div #(.NUM_W(NDC_N_W), .DEN_W(32), .Q_W(32)) u_div_z (
    .clk(clk), .en(en), .num({mag[2], FRAC'(0)}), .den(mag[3]), .quo(qz), .ovf(oz)
  );
  vtv_div #(.NUM_W(BRI_N_W), .DEN_W(BRI_D_W), .Q_W(32)) u_div_b (
    .clk(clk), .en(en), .num(bnum), .den(bden[BRI_D_W-1:0]), .quo(qb), .ovf(ob)
  );

  side_t side [DIV_LAT];
  logic  vd   [DIV_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= side_in;
      for (int i = 1; i < DIV_LAT; i++) begin
        side[i] <= side[i-1];
      end
    end
  end

  // stage 6: normalized coordinates, flags, brightness
  side_t              sd;
  logic signed [31:0] nx_c, ny_c, nz_c;
  logic [16:0]        minb;
  logic [16:0]        bq;
  logic [16:0]        bsel;
  logic signed [31:0] nx6, ny6, nz6;
  logic               xy6, z6, wz6;
  logic [47:0]        dist6;
  logic [16:0]        bri6;
  logic [15:0]        col6;
  logic               v6;

  assign sd   = side[DIV_LAT-1];
  assign nx_c = ndc_fix(qx, ox, sd.negx);
  assign ny_c = ndc_fix(qy, oy, sd.negy);
  assign nz_c = ndc_fix(qz, oz, sd.negz);
  assign minb = (min_brightness > BRI_ONE) ? BRI_ONE : min_brightness;
  assign bq   = (ob || (qb > 32'(BRI_ONE))) ? BRI_ONE : qb[16:0];

  always_comb begin
    if (sd.bzero) begin
      bsel = BRI_ONE;
    end else if (sd.bneg) begin
      bsel = minb;
    end else begin
      bsel = bq;
    end
    if (bsel < minb) begin
      bsel = minb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nx6   <= nx_c;
      ny6   <= ny_c;
      nz6   <= sd.wz ? 32'sd0 : nz_c;
      xy6   <= !sd.wz && (nx_c >= -ONE) && (nx_c <= ONE) && (ny_c >= -ONE) && (ny_c <= ONE);
      z6    <= !sd.wz && (nz_c >= -ONE) && (nz_c <= ONE);
      wz6   <= sd.wz;
      dist6 <= sd.dsq;
      bri6  <= bsel;
      col6  <= sd.color;
    end
  end

  // stage 7: viewport products
  logic [12:0]        wm1, hm1;
  logic signed [32:0] ax, ay;
  logic signed [46:0] px7, py7;
  logic signed [31:0] nz7;
  logic               xy7, z7, wz7;
  logic [47:0]        dist7;
  logic [16:0]        bri7;
  logic [15:0]        col7;
  logic               v7;

  assign wm1 = (frame_width == '0) ? '0 : frame_width - 1'b1;
  assign hm1 = (frame_height == '0) ? '0 : frame_height - 1'b1;
  assign ax  = 33'(nx6) + 33'(ONE);
  assign ay  = 33'(ONE) - 33'(ny6);

  always_ff @(posedge clk) begin
    if (en) begin
      px7   <= ax * $signed({1'b0, wm1});
      py7   <= ay * $signed({1'b0, hm1});
      nz7   <= nz6;
      xy7   <= xy6;
      z7    <= z6;
      wz7   <= wz6;
      dist7 <= dist6;
      bri7  <= bri6;
      col7  <= col6;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      pixel_x         <= wz7 ? 16'sd0 : pix_fix(px7);
      pixel_y         <= wz7 ? 16'sd0 : pix_fix(py7);
      depth_ndc       <= nz7;
      xy_in_view      <= xy7;
      z_in_view       <= z7;
      w_zero          <= wz7;
      eye_distance_sq <= dist7;
      brightness      <= bri7;
      color_out       <= col7;
    end
  end

  // valid chain
  logic vd_any;

  always_comb begin
    vd_any = 1'b0;
    for (int i = 0; i < DIV_LAT; i++) begin
      vd_any = vd_any | vd[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v6        <= 1'b0;
      v7        <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < DIV_LAT; i++) begin
        vd[i] <= 1'b0;
      end
    end else if (en) begin
      v1    <= pop;
      v2    <= v1;
      v3    <= v2;
      v4    <= v3;
      vd[0] <= v4;
      for (int i = 1; i < DIV_LAT; i++) begin
        vd[i] <= vd[i-1];
      end
      v6        <= vd[DIV_LAT-1];
      v7        <= v6;
      out_valid <= v7;
    end
  end

  assign busy = v1 || v2 || v3 || v4 || vd_any || v6 || v7 || out_valid;

endmodule

// ===== rtl/vertex_transform_viewport_top.sv =====
// Vertex transform with perspective divide, viewport map and distance brightness.
//
// Input channel (in_valid/in_ready) carries one request: opcode 0 writes one
// element of the projection or modelview matrix, opcode 1 transforms a vertex.
// Output channel (out_valid/out_ready) returns one result per vertex request;
// matrix writes return nothing.
// Vertex requests are taken one per cycle while the four-entry queue has room.
// A taken vertex passes through the queue, the product stages, the four pipelined
// divides (33 stages each), the viewport stage and the output register.
// A matrix write is taken only once the queue and pipeline hold no vertex,
// so it waits until the last vertex result has left the output register.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once; the user
// must make them while no vertex is in flight, which the block does not enforce.
// When out_valid is high and out_ready is low the whole pipeline holds; the queue
// keeps accepting until full, then in_ready drops for vertex requests.
// Reset clears both matrices to zero, loads register defaults, empties all.
module vertex_transform_viewport_top import vtv_pkg::*; #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  opcode,
  input  logic                  matrix_select,
  input  logic [3:0]            element_index,
  input  logic signed [31:0]    element_value,
  input  logic signed [31:0]    vx,
  input  logic signed [31:0]    vy,
  input  logic signed [31:0]    vz,
  input  logic signed [31:0]    vw,
  input  logic [15:0]           vertex_color,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [15:0]    pixel_x,
  output logic signed [15:0]    pixel_y,
  output logic signed [31:0]    depth_ndc,
  output logic                  xy_in_view,
  output logic                  z_in_view,
  output logic                  w_zero,
  output logic [47:0]           eye_distance_sq,
  output logic [16:0]           brightness,
  output logic [15:0]           color_out
);

  logic [12:0] frame_width;
  logic [12:0] frame_height;
  logic [19:0] light_start;
  logic [19:0] light_falloff;
  logic [16:0] min_brightness;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width    <= RST_FRAME_WIDTH;
      frame_height   <= RST_FRAME_HEIGHT;
      light_start    <= RST_LIGHT_START;
      light_falloff  <= RST_LIGHT_FALLOFF;
      min_brightness <= RST_MIN_BRIGHTNESS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:    frame_width    <= cfg_data[12:0];
        CFG_FRAME_HEIGHT:   frame_height   <= cfg_data[12:0];
        CFG_LIGHT_START:    light_start    <= cfg_data[19:0];
        CFG_LIGHT_FALLOFF:  light_falloff  <= cfg_data[19:0];
        CFG_MIN_BRIGHTNESS: min_brightness <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  q_status_t q_stat;
  logic      back_busy;
  logic      push;
  logic      pop;
  vtx_t      push_data;
  vtx_t      pop_data;
  mat_t      proj;
  mat_t      model;

  vtv_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .matrix_select(matrix_select), .element_index(element_index),
    .element_value(element_value), .vx(vx), .vy(vy), .vz(vz), .vw(vw),
    .vertex_color(vertex_color), .q_stat(q_stat), .back_busy(back_busy),
    .push(push), .push_data(push_data), .proj(proj), .model(model)
  );

  vtv_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_data(push_data), .pop(pop),
    .pop_data(pop_data), .q_stat(q_stat)
  );

  vtv_back #(.FRAC(FRACTION_BITS)) u_back (
    .clk(clk), .rst(rst), .q_stat(q_stat), .pop(pop), .pop_data(pop_data),
    .proj(proj), .model(model), .frame_width(frame_width), .frame_height(frame_height),
    .light_start(light_start), .light_falloff(light_falloff),
    .min_brightness(min_brightness), .busy(back_busy), .out_valid(out_valid),
    .out_ready(out_ready), .pixel_x(pixel_x), .pixel_y(pixel_y), .depth_ndc(depth_ndc),
    .xy_in_view(xy_in_view), .z_in_view(z_in_view), .w_zero(w_zero),
    .eye_distance_sq(eye_distance_sq), .brightness(brightness), .color_out(color_out)
  );

`ifndef SYNTHESIS
  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && opcode == OP_WRITE) |-> (!back_busy && q_stat.empty))
    else $error("matrix write taken while vertices in flight");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_stat.full)
    else $error("push into full queue");

  a_wzero_clear: assert property (@(posedge clk) disable iff (rst)
    (out_valid && w_zero) |-> (pixel_x == 16'sd0 && pixel_y == 16'sd0 &&
                               depth_ndc == 32'sd0 && !xy_in_view && !z_in_view))
    else $error("zero w result not cleared");

  a_bri_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (brightness <= BRI_ONE))
    else $error("brightness above one");
`endif

endmodule
